/* hdl/tbcf_pkg.sv */
// Package for the two-beat command front end.
// Holds the beat types, status codes, field positions and register indexes.
// Depends on nothing.
`default_nettype none

package tbcf_pkg;

	localparam int unsigned BEAT_W    = 64;
	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned ID_W      = 12;
	localparam int unsigned ID_NARROW = 10;
	localparam int unsigned ID_LSB    = 48;
	localparam int unsigned STATUS_W  = 8;
	localparam int unsigned FREE_W    = 8;
	localparam int unsigned RSP_W     = ID_W + STATUS_W + FREE_W;

	localparam logic [STATUS_W-1:0] STATUS_BAD_DESC = 8'd1;
	localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 8'd4;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIAG_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BEAT_TIMEOUT = 1'b1;
	localparam int unsigned CFG_DATA_W = TIMEOUT_W;

	typedef struct packed {
		logic                soft_reset;
		logic                host_valid;
		logic                host_first;
		logic                host_last;
		logic [BEAT_W-1:0]   host_data;
		logic                rsp_ready;
		logic [FREE_W-1:0]   free_tasks;
		logic [STATUS_W-1:0] backend_status;
	} tick_t;

	typedef struct packed {
		logic              host_ready;
		logic              rsp_valid;
		logic [RSP_W-1:0]  rsp_data;
		logic              submit_strobe;
		logic [BEAT_W-1:0] submit_low_beat;
		logic [BEAT_W-1:0] submit_high_beat;
	} result_t;

	function automatic logic [RSP_W-1:0] make_word(
		input logic [ID_W-1:0]     id,
		input logic [STATUS_W-1:0] status,
		input logic [FREE_W-1:0]   free_slots
	);
		return {free_slots, status, id};
	endfunction

endpackage

`default_nettype wire

/* hdl/tbcf_tick_reg.sv */
// Input register of the command front end: holds one tick beat until the
// engine takes it. Depends on tbcf_pkg.
`default_nettype none

module tbcf_tick_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           tick_valid,
	input  wire tbcf_pkg::tick_t tick,
	input  wire logic           take,
	output logic                tick_stall,
	output logic                valid_s1,
	output tbcf_pkg::tick_t     tick_s1
);
	import tbcf_pkg::*;

	logic accept;

	assign tick_stall = valid_s1 && !take;
	assign accept     = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick;
		end
	end

endmodule

`default_nettype wire

/* hdl/tbcf_engine.sv */
// Front end state and per-tick logic: beat assembly, timeout counter and the
// pending response word, plus the two configuration registers.
// Depends on tbcf_pkg.
`default_nettype none

module tbcf_engine (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [tbcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tbcf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           fire,
	input  wire tbcf_pkg::tick_t                tick_s1,
	output tbcf_pkg::result_t                   result_nxt
);
	import tbcf_pkg::*;

	logic                 diag_mode_q;
	logic [TIMEOUT_W-1:0] beat_timeout_q;

	logic                 hold_q;
	logic [BEAT_W-1:0]    first_beat_q;
	logic [TIMEOUT_W-1:0] wait_q;
	logic                 pend_valid_q;
	logic [RSP_W-1:0]     pend_word_q;

	logic                 hold_nxt;
	logic [BEAT_W-1:0]    first_beat_nxt;
	logic [TIMEOUT_W-1:0] wait_nxt;
	logic                 pend_valid_nxt;
	logic [RSP_W-1:0]     pend_word_nxt;

	logic                 ready;
	logic [TIMEOUT_W-1:0] wait_inc;
	logic [ID_W-1:0]      id_first;
	logic [ID_W-1:0]      id_data;
	logic [ID_W-1:0]      id_second;

	assign wait_inc  = wait_q + TIMEOUT_W'(1);
	assign id_first  = first_beat_q[ID_LSB +: ID_W];
	assign id_data   = tick_s1.host_data[ID_LSB +: ID_W];
	assign id_second = diag_mode_q ? id_first
		: {{(ID_W-ID_NARROW){1'b0}}, tick_s1.host_data[ID_LSB +: ID_NARROW]};

	always_comb begin
		hold_nxt       = hold_q;
		first_beat_nxt = first_beat_q;
		wait_nxt       = wait_q;
		pend_valid_nxt = pend_valid_q;
		pend_word_nxt  = pend_word_q;
		ready          = 1'b0;
		result_nxt           = '0;
		result_nxt.rsp_valid = pend_valid_q;
		result_nxt.rsp_data  = pend_word_q;

		if (tick_s1.soft_reset) begin
			hold_nxt             = 1'b0;
			first_beat_nxt       = '0;
			wait_nxt             = '0;
			pend_valid_nxt       = 1'b0;
			pend_word_nxt        = '0;
			result_nxt.rsp_valid = 1'b0;
			result_nxt.rsp_data  = '0;
		end else begin
			ready = !pend_valid_q && (hold_q || tick_s1.free_tasks != '0);
			if (pend_valid_q && tick_s1.rsp_ready) begin
				pend_valid_nxt = 1'b0;
			end
			if (tick_s1.host_valid && ready) begin
				if (!hold_q) begin
					if (!tick_s1.host_first || tick_s1.host_last) begin
						pend_word_nxt  = make_word(id_data, STATUS_BAD_DESC,
							tick_s1.free_tasks);
						pend_valid_nxt = 1'b1;
					end else begin
						first_beat_nxt = tick_s1.host_data;
						hold_nxt       = 1'b1;
						wait_nxt       = '0;
					end
				end else begin
					if (tick_s1.host_first || !tick_s1.host_last) begin
						pend_word_nxt = make_word(id_second, STATUS_BAD_DESC,
							tick_s1.free_tasks);
					end else begin
						pend_word_nxt = make_word(id_second, tick_s1.backend_status,
							tick_s1.free_tasks);
						result_nxt.submit_strobe    = 1'b1;
						result_nxt.submit_low_beat  = first_beat_q;
						result_nxt.submit_high_beat = tick_s1.host_data;
					end
					pend_valid_nxt = 1'b1;
					hold_nxt       = 1'b0;
					wait_nxt       = '0;
				end
			end else if (hold_q && beat_timeout_q != '0) begin
				wait_nxt = wait_inc;
				if (wait_inc >= beat_timeout_q) begin
					pend_word_nxt  = make_word(diag_mode_q ? id_first : '0,
						STATUS_TIMEOUT, tick_s1.free_tasks);
					pend_valid_nxt = 1'b1;
					hold_nxt       = 1'b0;
					wait_nxt       = '0;
				end
			end
		end
		result_nxt.host_ready = ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_mode_q    <= 1'b0;
			beat_timeout_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IDX_DIAG_MODE:    diag_mode_q    <= cfg_data[0];
				CFG_IDX_BEAT_TIMEOUT: beat_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q       <= 1'b0;
			first_beat_q <= '0;
			wait_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_word_q  <= '0;
		end else if (fire) begin
			hold_q       <= hold_nxt;
			first_beat_q <= first_beat_nxt;
			wait_q       <= wait_nxt;
			pend_valid_q <= pend_valid_nxt;
			pend_word_q  <= pend_word_nxt;
		end
	end

endmodule

`default_nettype wire

/* hdl/tbcf_result_reg.sv */
// Output register of the command front end: holds one result beat until the
// consumer takes it. Depends on tbcf_pkg.
`default_nettype none

module tbcf_result_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load_req,
	input  wire tbcf_pkg::result_t result_nxt,
	input  wire logic             result_stall,
	output logic                  room,
	output logic                  result_valid,
	output tbcf_pkg::result_t     result
);
	import tbcf_pkg::*;

	logic load;

	assign room = !result_valid || !result_stall;
	assign load = load_req && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (room) begin
			result_valid <= load_req;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result <= result_nxt;
		end
	end

endmodule

`default_nettype wire

/* hdl/two_beat_command_frontend.sv */
// Top level of the two-beat command front end.
// Instantiates tbcf_tick_reg, tbcf_engine and tbcf_result_reg; uses tbcf_pkg.
//
// Each tick beat on the input channel is one clock of a host command channel and gives
// exactly one result beat. A tick passes the input register, is evaluated combinationally
// against the front end state and lands in the result register, so one tick is taken every
// clock when nothing stalls, and its result beat is offered from the result register.
// A stalled result beat stalls the input while a tick waits behind it.
// The configuration port always accepts writes; change it only while no tick is in flight.
`default_nettype none

module two_beat_command_frontend (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tbcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tbcf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           tick_valid,
	output logic                                tick_stall,
	input  wire tbcf_pkg::tick_t                tick,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output tbcf_pkg::result_t                   result
);
	import tbcf_pkg::*;

	logic      valid_s1;
	tick_t     tick_s1;
	logic      room;
	logic      fire;
	result_t   result_nxt;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && room;

	tbcf_tick_reg u_tick_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick       (tick),
		.take       (room),
		.tick_stall (tick_stall),
		.valid_s1   (valid_s1),
		.tick_s1    (tick_s1)
	);

	tbcf_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fire       (fire),
		.tick_s1    (tick_s1),
		.result_nxt (result_nxt)
	);

	tbcf_result_reg u_result_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_req     (valid_s1),
		.result_nxt   (result_nxt),
		.result_stall (result_stall),
		.room         (room),
		.result_valid (result_valid),
		.result       (result)
	);

	// A beat can only be submitted on a tick where the channel was ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.submit_strobe |-> result.host_ready)
		else $error("submit strobe without channel ready");

	// The channel is never ready while a response is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.host_ready |-> !result.rsp_valid)
		else $error("channel ready with a pending response");

	// Without a submission the beat outputs are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.submit_strobe |->
		result.submit_low_beat == '0 && result.submit_high_beat == '0)
		else $error("submit beats nonzero without strobe");

	// The input side only stalls behind a held, stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> result_valid && result_stall)
		else $error("input stalled while the result register had room");

endmodule

`default_nettype wire
